### hdl/assert_macros.svh
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted.
`define BIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BIS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/bis_pkg.sv
// Types, widths and constants shared by the bilinear scaler modules.
package bis_pkg;

    localparam int POS_W   = 12;  // pos_x / pos_y
    localparam int PIX_W   = 32;
    localparam int SZ_W    = 9;   // source size registers
    localparam int TSZ_W   = 12;  // target size registers
    localparam int D_W     = TSZ_W + 1;          // 2 * target size
    localparam int N_W     = POS_W + 1 + SZ_W + 1; // signed source position numerator
    localparam int Q_W     = SZ_W;               // integer source coordinate
    localparam int CNT_W   = $clog2(Q_W);
    localparam int WT_W    = 2 * D_W;
    localparam int LANES   = 4;
    localparam int LANE_W  = 8;
    localparam int ACC_W   = WT_W + LANE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = TSZ_W;
    localparam int Q_DEPTH = 4;

    localparam int DEF_MAX_SRC_W = 256;
    localparam int DEF_MAX_SRC_H = 256;

    localparam logic [SZ_W-1:0]  RST_SRC_SIZE = SZ_W'(256);
    localparam logic [TSZ_W-1:0] RST_TGT_SIZE = TSZ_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_H = 2'd3;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam logic CMD_WRITE = 1'b0;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_QUERY = 2'd1,
        K_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [PIX_W-1:0]  pixel;
    } t_cmd;

    typedef struct packed {
        logic [SZ_W-1:0]  sw;
        logic [SZ_W-1:0]  sh;
        logic [TSZ_W-1:0] tw;
        logic [TSZ_W-1:0] th;
    } t_geom;

    // Zero acts as one, anything above the memory size acts as that size.
    function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v, input int maxv);
        logic [SZ_W-1:0] res;
        if (v == '0)
            res = SZ_W'(1);
        else if (int'(v) > maxv)
            res = SZ_W'(maxv);
        else
            res = v;
        return res;
    endfunction

endpackage

### hdl/bilinear_image_scaler.sv
// Bilinear image scaler top level: front end, command queue and back end.
//
// The front end takes one command per cycle while the 4-entry command queue has room:
// source writes outside the configured source size are dropped there, and queries are
// checked against the target size. The back end owns the single-port source image memory.
// A source write or an out-of-range query is handled in the idle state; an in-range query
// runs the serial coordinate divider (9 steps), the four neighbor reads from the one
// memory port, and the serial per-lane blend divider (8 steps). One result waits in an
// output register; while it is not popped, commands are taken until the queue is full.
// The image memory is not cleared; a query of a never-written pixel returns undefined data.
module bilinear_image_scaler #(
    parameter int MAX_SOURCE_WIDTH  = bis_pkg::DEF_MAX_SRC_W,
    parameter int MAX_SOURCE_HEIGHT = bis_pkg::DEF_MAX_SRC_H
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bis_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_command,
    input  logic [bis_pkg::POS_W-1:0]     i_pos_x,
    input  logic [bis_pkg::POS_W-1:0]     i_pos_y,
    input  logic [bis_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [bis_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_status
);
    import bis_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_cmd  q_in;
    t_cmd  q_out;
    t_geom geom;

    assign o_full = q_full;

    bis_front #(
        .MAX_W (MAX_SOURCE_WIDTH),
        .MAX_H (MAX_SOURCE_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_command   (i_command),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pixel_in  (i_pixel_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in),
        .o_geom      (geom)
    );

    bis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    bis_back #(
        .MAX_W (MAX_SOURCE_WIDTH),
        .MAX_H (MAX_SOURCE_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .i_geom      (geom),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_pixel_out (o_pixel_out),
        .o_status    (o_status)
    );

endmodule

### hdl/bis_queue.sv
// Command queue between the scaler front end and back end.
module bis_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bis_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output bis_pkg::t_cmd o_data
);
    import bis_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok)
                r_wr <= r_wr + PW'(1);
            if (pop_ok)
                r_rd <= r_rd + PW'(1);
            r_count <= r_count + CW'(push_ok) - CW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok)
            r_mem[r_wr] <= i_data;
    end

`include "assert_macros.svh"
    `BIS_ASSERT(a_q_count_bound, r_count <= CW'(Q_DEPTH), "queue count above depth")
    `BIS_ASSERT(a_q_no_push_full, i_push |-> !o_full, "front pushed into a full queue")

endmodule

### hdl/bis_front.sv
// Scaler front end: configuration registers and command classification.
module bis_front #(
    parameter int MAX_W = bis_pkg::DEF_MAX_SRC_W,
    parameter int MAX_H = bis_pkg::DEF_MAX_SRC_H
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_command,
    input  logic [bis_pkg::POS_W-1:0]      i_pos_x,
    input  logic [bis_pkg::POS_W-1:0]      i_pos_y,
    input  logic [bis_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output bis_pkg::t_cmd                  o_q_data,
    output bis_pkg::t_geom                 o_geom
);
    import bis_pkg::*;

    logic [SZ_W-1:0]  r_src_w;
    logic [SZ_W-1:0]  r_src_h;
    logic [TSZ_W-1:0] r_tgt_w;
    logic [TSZ_W-1:0] r_tgt_h;
    logic [SZ_W-1:0]  sw;
    logic [SZ_W-1:0]  sh;
    logic             wr_inside;
    logic             q_inside;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_SIZE;
            r_src_h <= RST_SRC_SIZE;
            r_tgt_w <= RST_TGT_SIZE;
            r_tgt_h <= RST_TGT_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_W: r_src_w <= i_cfg_data[SZ_W-1:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[SZ_W-1:0];
                CFG_TGT_W: r_tgt_w <= i_cfg_data;
                CFG_TGT_H: r_tgt_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sw = eff_size(r_src_w, MAX_W);
    assign sh = eff_size(r_src_h, MAX_H);

    assign wr_inside = (i_pos_x < POS_W'(sw)) && (i_pos_y < POS_W'(sh));
    assign q_inside  = (i_pos_x < r_tgt_w) && (i_pos_y < r_tgt_h);

    // Drop writes that fall outside the source image.
    assign o_q_push = i_push && !i_q_full && (i_command != CMD_WRITE || wr_inside);

    always_comb begin
        o_q_data.x     = i_pos_x;
        o_q_data.y     = i_pos_y;
        o_q_data.pixel = i_pixel_in;
        if (i_command == CMD_WRITE)
            o_q_data.kind = K_WRITE;
        else if (q_inside)
            o_q_data.kind = K_QUERY;
        else
            o_q_data.kind = K_ERROR;
    end

    assign o_geom.sw = sw;
    assign o_geom.sh = sh;
    assign o_geom.tw = r_tgt_w;
    assign o_geom.th = r_tgt_h;

endmodule

### hdl/bis_back.sv
// Scaler back end: source image memory, coordinate mapping, blending and result register.
module bis_back #(
    parameter int MAX_W = bis_pkg::DEF_MAX_SRC_W,
    parameter int MAX_H = bis_pkg::DEF_MAX_SRC_H
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  bis_pkg::t_cmd              i_q_data,
    output logic                       o_q_pop,
    input  bis_pkg::t_geom             i_geom,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [bis_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                       o_status
);
    import bis_pkg::*;

    localparam int DEPTH = MAX_W * MAX_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_W);
    localparam int YW    = $clog2(MAX_H);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SETUP = 8'b00000010,
        S_DIV   = 8'b00000100,
        S_MAP   = 8'b00001000,
        S_WGT   = 8'b00010000,
        S_RD    = 8'b00100000,
        S_LDIV  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    function automatic logic [AW-1:0] pix_addr(input logic [POS_W-1:0] x,
                                                input logic [POS_W-1:0] y);
        return AW'(int'(y) * MAX_W + int'(x));
    endfunction

    t_state            r_state;
    t_state            n_state;
    logic [PIX_W-1:0]  mem [DEPTH];
    logic [PIX_W-1:0]  r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;

    logic [POS_W-1:0]  r_qx, r_qy;
    logic [N_W-1:0]    r_nx, r_ny;
    logic [N_W-1:0]    r_remx, r_remy;
    logic [N_W-1:0]    r_dshx, r_dshy;
    logic [Q_W-1:0]    r_ax, r_ay;
    logic [CNT_W-1:0]  r_cnt;
    logic [XW-1:0]     r_x0, r_x1;
    logic [YW-1:0]     r_y0, r_y1;
    logic [D_W-1:0]    r_rx, r_ry;
    logic [WT_W-1:0]   r_w [4];
    logic [WT_W-1:0]   r_den;
    logic [2:0]        r_k;
    logic [ACC_W-1:0]  r_acc [LANES];
    logic [ACC_W-1:0]  r_dden;
    logic [LANE_W-1:0] r_q [LANES];

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_status;
    logic              out_free;
    logic              out_load;
    logic [PIX_W-1:0]  out_pix;
    logic              out_status;

    logic [D_W-1:0]    dx, dy;
    logic [21:0]       prod_x, prod_y;
    logic [Q_W:0]      ax1, ay1;
    logic [Q_W:0]      xmax, ymax;
    logic [POS_W-1:0]  sel_x, sel_y;

    assign out_free = !r_out_valid || i_pop;
    assign dx = {i_geom.tw, 1'b0};
    assign dy = {i_geom.th, 1'b0};
    assign prod_x = 22'({r_qx, 1'b1} * i_geom.sw);
    assign prod_y = 22'({r_qy, 1'b1} * i_geom.sh);
    assign ax1  = {1'b0, r_ax} + (Q_W+1)'(1);
    assign ay1  = {1'b0, r_ay} + (Q_W+1)'(1);
    assign xmax = {1'b0, i_geom.sw} - (Q_W+1)'(1);
    assign ymax = {1'b0, i_geom.sh} - (Q_W+1)'(1);
    assign sel_x = r_k[0] ? POS_W'(r_x1) : POS_W'(r_x0);
    assign sel_y = r_k[1] ? POS_W'(r_y1) : POS_W'(r_y0);

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pix_addr(i_q_data.x, i_q_data.y);
        out_load   = 1'b0;
        out_pix    = '0;
        out_status = ST_OK;
        for (int l = 0; l < LANES; l++)
            out_pix[l*LANE_W +: LANE_W] = r_q[l];
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_data.kind)
                        K_WRITE: begin
                            mem_we  = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        K_QUERY: begin
                            o_q_pop = 1'b1;
                            n_state = S_SETUP;
                        end
                        K_ERROR: begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                out_pix    = '0;
                                out_status = ST_ERR;
                                o_q_pop    = 1'b1;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            S_SETUP: n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(Q_W - 1)) n_state = S_MAP;
            S_MAP:   n_state = S_WGT;
            S_WGT:   n_state = S_RD;
            S_RD: begin
                mem_addr = pix_addr(sel_x, sel_y);
                if (r_k == 3'd4)
                    n_state = S_LDIV;
            end
            S_LDIV:  if (r_cnt == CNT_W'(LANE_W - 1)) n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[mem_addr] <= i_q_data.pixel;
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qx <= i_q_data.x;
                r_qy <= i_q_data.y;
            end
            S_SETUP: begin
                r_nx   <= N_W'({1'b0, prod_x}) - N_W'(i_geom.tw);
                r_ny   <= N_W'({1'b0, prod_y}) - N_W'(i_geom.th);
                r_remx <= N_W'({1'b0, prod_x}) - N_W'(i_geom.tw);
                r_remy <= N_W'({1'b0, prod_y}) - N_W'(i_geom.th);
                r_dshx <= N_W'(dx) << (Q_W - 1);
                r_dshy <= N_W'(dy) << (Q_W - 1);
                r_ax   <= '0;
                r_ay   <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                // one quotient bit per axis per cycle
                if (r_remx >= r_dshx) begin
                    r_remx <= r_remx - r_dshx;
                    r_ax   <= {r_ax[Q_W-2:0], 1'b1};
                end else begin
                    r_ax   <= {r_ax[Q_W-2:0], 1'b0};
                end
                if (r_remy >= r_dshy) begin
                    r_remy <= r_remy - r_dshy;
                    r_ay   <= {r_ay[Q_W-2:0], 1'b1};
                end else begin
                    r_ay   <= {r_ay[Q_W-2:0], 1'b0};
                end
                r_dshx <= r_dshx >> 1;
                r_dshy <= r_dshy >> 1;
                r_cnt  <= (r_cnt == CNT_W'(Q_W - 1)) ? '0 : r_cnt + CNT_W'(1);
            end
            S_MAP: begin
                // left of the first centre: floor is -1, both neighbors clamp to zero
                if (r_nx[N_W-1]) begin
                    r_rx <= D_W'(r_nx + N_W'(dx));
                    r_x0 <= '0;
                    r_x1 <= '0;
                end else begin
                    r_rx <= D_W'(r_remx);
                    r_x0 <= XW'(r_ax);
                    r_x1 <= (ax1 > xmax) ? XW'(xmax) : XW'(ax1);
                end
                if (r_ny[N_W-1]) begin
                    r_ry <= D_W'(r_ny + N_W'(dy));
                    r_y0 <= '0;
                    r_y1 <= '0;
                end else begin
                    r_ry <= D_W'(r_remy);
                    r_y0 <= YW'(r_ay);
                    r_y1 <= (ay1 > ymax) ? YW'(ymax) : YW'(ay1);
                end
            end
            S_WGT: begin
                r_w[0] <= WT_W'(dx - r_rx) * WT_W'(dy - r_ry);
                r_w[1] <= WT_W'(r_rx) * WT_W'(dy - r_ry);
                r_w[2] <= WT_W'(dx - r_rx) * WT_W'(r_ry);
                r_w[3] <= WT_W'(r_rx) * WT_W'(r_ry);
                r_den  <= WT_W'(dx) * WT_W'(dy);
                r_k    <= '0;
            end
            S_RD: begin
                // r_rdata is the registered read of the address issued in the step before
                for (int l = 0; l < LANES; l++) begin
                    if (r_k == 3'd0)
                        r_acc[l] <= '0;
                    else
                        r_acc[l] <= r_acc[l] + ACC_W'(r_rdata[l*LANE_W +: LANE_W])
                                    * ACC_W'(r_w[r_k[1:0] - 2'd1]);
                end
                r_k    <= r_k + 3'd1;
                r_dden <= ACC_W'(r_den) << (LANE_W - 1);
                r_cnt  <= '0;
            end
            S_LDIV: begin
                for (int l = 0; l < LANES; l++) begin
                    if (r_acc[l] >= r_dden) begin
                        r_acc[l] <= r_acc[l] - r_dden;
                        r_q[l]   <= {r_q[l][LANE_W-2:0], 1'b1};
                    end else begin
                        r_q[l]   <= {r_q[l][LANE_W-2:0], 1'b0};
                    end
                end
                r_dden <= r_dden >> 1;
                r_cnt  <= (r_cnt == CNT_W'(LANE_W - 1)) ? '0 : r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_load)
            r_out_valid <= 1'b1;
        else if (i_pop)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pix    <= out_pix;
            r_out_status <= out_status;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_status    = r_out_status;

`include "assert_macros.svh"
    `BIS_ASSERT(a_state_onehot, $onehot(r_state), "back end state not one-hot")
    `BIS_ASSERT(a_div_count, (r_state == S_DIV) |-> (r_cnt < CNT_W'(Q_W)), "divider ran past its steps")
    `BIS_ASSERT(a_load_free, out_load |-> out_free, "result register overwritten")

endmodule
